FILE: hdl/cpr_pkg.sv
// shared types and constants for the clock page replacement block
// no dependencies; imported by every module of the block
package cpr_pkg;

    localparam int PAGE_W = 16;
    localparam int SLOT_W = 4;
    localparam int CFG_W  = 5;
    localparam int COUNT_W = 16;

    localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_SWEEP  = 5'b00100,
        ST_LOAD   = 5'b01000,
        ST_RESULT = 5'b10000
    } t_state;

    // flags from the shared step unit
    typedef struct packed {
        logic match;
        logic at_end;
    } t_step_flags;

endpackage

FILE: hdl/cpr_page_ram.sv
// resident page store: one write port, one registered read port
// depends on cpr_pkg for the page width
module cpr_page_ram
    import cpr_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [AW-1:0]     i_waddr,
    input  logic [PAGE_W-1:0] i_wdata,
    input  logic [AW-1:0]     i_raddr,
    output logic [PAGE_W-1:0] o_rdata
);

    logic [PAGE_W-1:0] r_mem [DEPTH];
    logic [PAGE_W-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/cpr_step_unit.sv
// shared step unit: page compare plus index increment with wrap at the frame count
// depends on cpr_pkg for the page width and the flag struct
module cpr_step_unit
    import cpr_pkg::*;
#(
    parameter int IW = 4,
    parameter int CW = 5
) (
    input  logic [IW-1:0]     i_idx,
    input  logic [CW-1:0]     i_count,
    input  logic [PAGE_W-1:0] i_page,
    input  logic [PAGE_W-1:0] i_rdata,
    input  logic              i_slot_valid,
    output t_step_flags       o_flags,
    output logic [IW-1:0]     o_next_idx
);

    logic [CW-1:0] w_inc;

    // one step forward, wrapping to zero at the frame count
    assign w_inc          = CW'(i_idx) + CW'(1);
    assign o_flags.at_end = (w_inc >= i_count);
    assign o_next_idx     = o_flags.at_end ? '0 : w_inc[IW-1:0];

    // a slot hits only when it holds a loaded page
    assign o_flags.match  = i_slot_valid && (i_rdata == i_page);

endmodule

FILE: hdl/clock_page_replacement.sv
// clock page replacement: hit search one slot per cycle, then hand sweep one slot per cycle
// a new page beat is taken only in idle, so each reference is finished and its result
// handed to the output register before the next one is accepted
// the search and the sweep share the single compare/step unit and the one read port of the
// page store
// reset: synchronous active low; clears valid and reference bits, hand, fault count, frames to 16
module clock_page_replacement
    import cpr_pkg::*;
#(
    parameter int MAX_FRAMES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [PAGE_W-1:0]  i_page_number,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic               o_fault,
    output logic [SLOT_W-1:0]  o_slot,
    output logic               o_evicted_valid,
    output logic [PAGE_W-1:0]  o_evicted_page,
    output logic [COUNT_W-1:0] o_fault_count
);

    localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CW = $clog2(MAX_FRAMES + 1);

    t_state              r_state, n_state;
    logic [CFG_W-1:0]    r_frames, n_frames;
    logic [PAGE_W-1:0]   r_page, n_page;
    logic [IW-1:0]       r_idx, n_idx;
    logic [IW-1:0]       r_hand, n_hand;
    logic [MAX_FRAMES-1:0] r_valid, n_valid;
    logic [MAX_FRAMES-1:0] r_ref, n_ref;
    logic [COUNT_W-1:0]  r_fault_total, n_fault_total;
    logic                r_res_fault, n_res_fault;
    logic [IW-1:0]       r_res_slot, n_res_slot;
    logic                r_res_ev_valid, n_res_ev_valid;
    logic [PAGE_W-1:0]   r_res_ev_page, n_res_ev_page;
    logic                r_out_valid, n_out_valid;
    logic                r_out_fault, n_out_fault;
    logic [SLOT_W-1:0]   r_out_slot, n_out_slot;
    logic                r_out_ev_valid, n_out_ev_valid;
    logic [PAGE_W-1:0]   r_out_ev_page, n_out_ev_page;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;

    logic [CW-1:0]       w_count;
    logic [IW-1:0]       w_unit_idx;
    logic [IW-1:0]       w_next_idx;
    logic [IW-1:0]       w_rd_addr;
    logic                w_mem_we;
    logic [PAGE_W-1:0]   w_rdata;
    t_step_flags         w_flags;
    logic                w_in_beat;
    logic                w_out_free;

    // frame count clamped to 1..MAX_FRAMES
    always_comb begin
        if (r_frames == '0) begin
            w_count = CW'(1);
        end else if (32'(r_frames) > MAX_FRAMES) begin
            w_count = CW'(MAX_FRAMES);
        end else begin
            w_count = CW'(r_frames);
        end
    end

    assign w_in_beat  = i_in_valid && (r_state == ST_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_unit_idx = (r_state == ST_SCAN) ? r_idx : r_hand;
    assign w_mem_we   = (r_state == ST_LOAD);

    // page store
    cpr_page_ram #(
        .DEPTH (MAX_FRAMES),
        .AW    (IW)
    ) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (r_hand),
        .i_wdata (r_page),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rdata)
    );

    // shared compare and step unit
    cpr_step_unit #(
        .IW (IW),
        .CW (CW)
    ) u_step_unit (
        .i_idx        (w_unit_idx),
        .i_count      (w_count),
        .i_page       (r_page),
        .i_rdata      (w_rdata),
        .i_slot_valid (r_valid[r_idx]),
        .o_flags      (w_flags),
        .o_next_idx   (w_next_idx)
    );

    // sequencer and table update
    always_comb begin
        n_state        = r_state;
        n_frames       = r_frames;
        n_page         = r_page;
        n_idx          = r_idx;
        n_hand         = r_hand;
        n_valid        = r_valid;
        n_ref          = r_ref;
        n_fault_total  = r_fault_total;
        n_res_fault    = r_res_fault;
        n_res_slot     = r_res_slot;
        n_res_ev_valid = r_res_ev_valid;
        n_res_ev_page  = r_res_ev_page;
        n_out_valid    = r_out_valid;
        n_out_fault    = r_out_fault;
        n_out_slot     = r_out_slot;
        n_out_ev_valid = r_out_ev_valid;
        n_out_ev_page  = r_out_ev_page;
        n_out_count    = r_out_count;
        w_rd_addr      = '0;

        if (i_cfg_we) begin
            n_frames = i_cfg_data;
        end

        // output beat taken
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                w_rd_addr = '0;
                if (w_in_beat) begin
                    n_page  = i_page_number;
                    n_idx   = '0;
                    // hand left beyond a lowered frame count restarts at zero
                    if (CW'(r_hand) >= w_count) begin
                        n_hand = '0;
                    end
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                w_rd_addr = w_next_idx;
                n_idx     = w_next_idx;
                if (w_flags.match) begin
                    n_ref[r_idx]   = 1'b1;
                    n_res_fault    = 1'b0;
                    n_res_slot     = r_idx;
                    n_res_ev_valid = 1'b0;
                    n_res_ev_page  = '0;
                    n_state        = ST_RESULT;
                end else if (w_flags.at_end) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                // fetch the candidate victim for the eviction report
                w_rd_addr = r_hand;
                if (r_ref[r_hand]) begin
                    n_ref[r_hand] = 1'b0;
                    n_hand        = w_next_idx;
                end else begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_res_fault    = 1'b1;
                n_res_slot     = r_hand;
                n_res_ev_valid = r_valid[r_hand];
                n_res_ev_page  = r_valid[r_hand] ? w_rdata : '0;
                n_valid[r_hand] = 1'b1;
                n_ref[r_hand]   = 1'b0;
                n_hand          = w_next_idx;
                if (r_fault_total != COUNT_MAX) begin
                    n_fault_total = r_fault_total + COUNT_W'(1);
                end
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                if (w_out_free) begin
                    n_out_valid    = 1'b1;
                    n_out_fault    = r_res_fault;
                    n_out_slot     = SLOT_W'(r_res_slot);
                    n_out_ev_valid = r_res_ev_valid;
                    n_out_ev_page  = r_res_ev_page;
                    n_out_count    = r_fault_total;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_frames      <= CFG_RESET;
            r_hand        <= '0;
            r_valid       <= '0;
            r_ref         <= '0;
            r_fault_total <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_frames      <= n_frames;
            r_hand        <= n_hand;
            r_valid       <= n_valid;
            r_ref         <= n_ref;
            r_fault_total <= n_fault_total;
            r_out_valid   <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_page         <= n_page;
        r_idx          <= n_idx;
        r_res_fault    <= n_res_fault;
        r_res_slot     <= n_res_slot;
        r_res_ev_valid <= n_res_ev_valid;
        r_res_ev_page  <= n_res_ev_page;
        r_out_fault    <= n_out_fault;
        r_out_slot     <= n_out_slot;
        r_out_ev_valid <= n_out_ev_valid;
        r_out_ev_page  <= n_out_ev_page;
        r_out_count    <= n_out_count;
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_fault         = r_out_fault;
    assign o_slot          = r_out_slot;
    assign o_evicted_valid = r_out_ev_valid;
    assign o_evicted_page  = r_out_ev_page;
    assign o_fault_count   = r_out_count;

    // an accepted beat always starts the hit search
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_beat |=> (r_state == ST_SCAN))
        else $error("accepted beat did not start the hit search");

    // the hand stays inside the frame count while sweeping
    a_hand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP || r_state == ST_LOAD) |-> (CW'(r_hand) < w_count))
        else $error("clock hand beyond frame count during sweep");

    // the victim always has a clear reference bit
    a_victim_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> !r_ref[r_hand])
        else $error("victim slot still has its reference bit set");

    // a hit never reports an eviction
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_fault) |-> (!r_out_ev_valid && r_out_ev_page == '0))
        else $error("hit result carries an eviction");

    // the fault total never goes down
    a_count_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_fault_total >= $past(r_fault_total)))
        else $error("fault total decreased");

endmodule

FILE: bench/cpr_checker.sv
// checker for the clock page replacement block: watches the config port and both channels,
// predicts each result from its own copy of the frame table and compares beat by beat
// depends on cpr_pkg for field widths
module cpr_checker
    import cpr_pkg::*;
#(
    parameter int MAX_FRAMES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [PAGE_W-1:0]  i_page_number,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_fault,
    input  logic [SLOT_W-1:0]  i_slot,
    input  logic               i_evicted_valid,
    input  logic [PAGE_W-1:0]  i_evicted_page,
    input  logic [COUNT_W-1:0] i_fault_count,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               fault;
        logic [SLOT_W-1:0]  slot;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [COUNT_W-1:0] fault_count;
    } t_outcome;

    t_outcome           outcome_q[$];
    logic [PAGE_W-1:0]  frame_page   [MAX_FRAMES];
    logic               frame_loaded [MAX_FRAMES];
    logic               frame_ref    [MAX_FRAMES];
    int                 hand;
    logic [COUNT_W-1:0] fault_tally;
    logic [CFG_W-1:0]   frames_reg;
    int                 fail_count = 0;
    int                 checked    = 0;
    int                 hits       = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = outcome_q.size();
    assign o_checked    = checked;
    assign o_hits       = hits;

    // one page reference: hit search over active frames, else second-chance sweep and load
    function automatic t_outcome access_page(input logic [PAGE_W-1:0] page);
        t_outcome res;
        int       active;
        int       victim;
        active = (frames_reg == '0) ? 1 : ((frames_reg > MAX_FRAMES) ? MAX_FRAMES : frames_reg);
        res = '0;
        // hand left past a lowered frame count restarts at slot zero
        if (hand >= active)
            hand = 0;
        for (int i = 0; i < active; i++) begin
            if (frame_loaded[i] && frame_page[i] == page) begin
                frame_ref[i]    = 1'b1;
                res.slot        = SLOT_W'(i);
                res.fault_count = fault_tally;
                return res;
            end
        end
        // give every referenced frame a second chance
        while (frame_ref[hand]) begin
            frame_ref[hand] = 1'b0;
            hand = (hand + 1 >= active) ? 0 : hand + 1;
        end
        victim = hand;
        if (frame_loaded[victim]) begin
            res.evicted_valid = 1'b1;
            res.evicted_page  = frame_page[victim];
        end
        frame_page[victim]   = page;
        frame_loaded[victim] = 1'b1;
        frame_ref[victim]    = 1'b0;
        hand = (hand + 1 >= active) ? 0 : hand + 1;
        if (fault_tally != COUNT_MAX)
            fault_tally = fault_tally + 1'b1;
        res.fault       = 1'b1;
        res.slot        = SLOT_W'(victim);
        res.fault_count = fault_tally;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // sample both channels and the config port on the rising edge
    always @(posedge i_clk) begin
        t_outcome exp_o;
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_FRAMES; i++) begin
                frame_page[i]   = '0;
                frame_loaded[i] = 1'b0;
                frame_ref[i]    = 1'b0;
            end
            hand        = 0;
            fault_tally = '0;
            frames_reg  = CFG_RESET;
            outcome_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (outcome_q.size() == 0) begin
                    $error("result beat with no pending expectation");
                    fail_count++;
                end else begin
                    exp_o = outcome_q.pop_front();
                    check_field("fault", 32'(exp_o.fault), 32'(i_fault));
                    check_field("slot", 32'(exp_o.slot), 32'(i_slot));
                    check_field("evicted_valid", 32'(exp_o.evicted_valid),
                                32'(i_evicted_valid));
                    check_field("evicted_page", 32'(exp_o.evicted_page),
                                32'(i_evicted_page));
                    check_field("fault_count", 32'(exp_o.fault_count), 32'(i_fault_count));
                    checked++;
                    if (!exp_o.fault)
                        hits++;
                end
            end
            if (i_cfg_we)
                frames_reg = i_cfg_data;
            if (i_in_valid && !i_in_stall)
                outcome_q.push_back(access_page(i_page_number));
        end
    end

endmodule

FILE: bench/tb_top.sv
// top of the clock page replacement bench: clock, reset, page stimulus and the verdict
// depends on cpr_pkg, clock_page_replacement and cpr_checker
module tb_top;
    import cpr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int SETTLE_CYCLES = 40;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [CFG_W-1:0]   i_cfg_data = CFG_RESET;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [PAGE_W-1:0]  i_page_number = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic               o_fault;
    logic [SLOT_W-1:0]  o_slot;
    logic               o_evicted_valid;
    logic [PAGE_W-1:0]  o_evicted_page;
    logic [COUNT_W-1:0] o_fault_count;

    int fail_count, pending, checked, hits;
    int sender_idle_pct = 0;
    int sink_stall_pct = 0;
    int cycle_count = 0;
    int frame_plan [8] = '{16, 1, 7, 31, 4, 0, 12, 3};

    always #10 i_clk = ~i_clk;

    clock_page_replacement u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_page_number   (i_page_number),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_fault         (o_fault),
        .o_slot          (o_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_page  (o_evicted_page),
        .o_fault_count   (o_fault_count)
    );

    cpr_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_page_number   (i_page_number),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_fault         (o_fault),
        .i_slot          (o_slot),
        .i_evicted_valid (o_evicted_valid),
        .i_evicted_page  (o_evicted_page),
        .i_fault_count   (o_fault_count),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_hits          (hits)
    );

    // receiver back-pressure
    always @(negedge i_clk)
        i_out_stall <= ($urandom_range(99) < sink_stall_pct);

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // one page beat; entered and left at a falling edge, valid left high for the next beat
    task automatic send_page(input logic [PAGE_W-1:0] page);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_page_number <= page;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // hold the sender until every outstanding result has been taken
    task automatic wait_results();
        i_in_valid <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
    endtask

    // drain then let the block fall idle before touching the frame count
    task automatic settle_and_write(input logic [CFG_W-1:0] frames);
        wait_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= frames;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
            1: begin sender_idle_pct = 64; sink_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  sink_stall_pct = 64; end
            default: begin sender_idle_pct = 17; sink_stall_pct = 17; end
        endcase
    endtask

    initial begin
        int               active;
        int               span;
        logic [PAGE_W-1:0] mask;
        logic [PAGE_W-1:0] page;

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: unfilled frames, hits, extremes of the page field, reset frame count
        send_page(16'h0000);
        send_page(16'h0000);
        send_page(16'hFFFF);
        send_page(16'hFFFF);
        send_page(16'h5555);
        send_page(16'hAAAA);
        send_page(16'h1234);
        // shrink below the hand: hand restarts, slot four no longer searched, sweep clears bits
        settle_and_write(5'd3);
        send_page(16'h1234);
        send_page(16'h0000);
        send_page(16'h0007);
        send_page(16'h0008);
        send_page(16'h0009);
        // zero frames acts as one
        settle_and_write(5'd0);
        send_page(16'h0009);
        send_page(16'h0009);
        send_page(16'h000A);
        send_page(16'h000B);
        // above range acts as the maximum; kept frames beyond the old count hit again
        settle_and_write(5'd31);
        send_page(16'hAAAA);
        send_page(16'h0008);
        send_page(16'hFFFF);
        send_page(16'h8001);

        // random: small page pools per frame count so hits and evictions both happen
        for (int ph = 0; ph < 8; ph++) begin
            settle_and_write(CFG_W'(frame_plan[ph]));
            set_idling(ph);
            active = (frame_plan[ph] == 0) ? 1 : ((frame_plan[ph] > 16) ? 16 : frame_plan[ph]);
            span = active + active / 2 + 1;
            mask = PAGE_W'($urandom);
            repeat (140) begin
                if ($urandom_range(9) == 0)
                    page = PAGE_W'($urandom);
                else
                    page = PAGE_W'($urandom_range(span)) ^ mask;
                send_page(page);
                if ($urandom_range(59) == 0)
                    wait_results();
            end
        end

        // a last mixed burst at the full frame count
        settle_and_write(5'd16);
        set_idling(3);
        repeat (30)
            send_page(PAGE_W'($urandom_range(24)));

        wait_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        $display("covered %0d page references: %0d hits, %0d faults", checked, hits,
                 checked - hits);
        $display("frame counts 0, 1, 3, 4, 7, 12, 16, 31, four idling mixes, drain pauses");
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
